// ===== rtl/dda_line_rasterizer_macros.svh =====
// Assertion helpers for the line rasteriser.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dlr_pkg.sv =====
`default_nettype none
package dlr_pkg;

	localparam int PORT_COORD_W = 10;

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	typedef struct packed {
		logic load_out;
		logic start;
		logic advance;
		logic stale;
		logic div_step;
		logic div_last;
	} dlr_cmd_t;

	typedef struct packed {
		logic line_active;
		logic zero_len;
		logic last_step;
	} dlr_status_t;

endpackage
`default_nettype wire

// ===== rtl/dlr_if.sv =====
`default_nettype none
interface dlr_req_if import dlr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [PORT_COORD_W-1:0] x_start;
	logic [PORT_COORD_W-1:0] y_start;
	logic [PORT_COORD_W-1:0] x_end;
	logic [PORT_COORD_W-1:0] y_end;

	modport source (output valid, req_type, x_start, y_start, x_end, y_end, input ready);
	modport sink (input valid, req_type, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dlr_pix_if import dlr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [PORT_COORD_W-1:0] pix_x;
	logic [PORT_COORD_W-1:0] pix_y;
	logic                    last;
	logic                    stale;

	modport source (output valid, pix_x, pix_y, last, stale, input ready);
	modport sink (input valid, pix_x, pix_y, last, stale, output ready);
endinterface
`default_nettype wire

// ===== rtl/dlr_divider.sv =====
`default_nettype none
module dlr_divider import dlr_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic                  step,
	input  logic [COORD_BITS-1:0] mag,
	input  logic [COORD_BITS-1:0] steps,
	output logic [FRAC_BITS:0]    quo
);

	// restoring division, one quotient bit a cycle while step is high; mag <= steps so the
	// quotient needs FRAC_BITS+1 bits
	logic [COORD_BITS:0]   rem_q;
	logic [COORD_BITS-1:0] steps_q;
	logic [FRAC_BITS:0]    quo_q;
	logic [COORD_BITS:0]   divisor;
	logic [COORD_BITS:0]   diff;
	logic [COORD_BITS:0]   rem_nx;
	logic                  ge;

	assign divisor = {1'b0, steps_q};
	assign ge      = rem_q >= divisor;
	assign diff    = rem_q - divisor;
	assign rem_nx  = ge ? diff : rem_q;
	assign quo     = {quo_q[FRAC_BITS-1:0], ge};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q   <= {1'b0, mag};
			steps_q <= steps;
			quo_q   <= '0;
		end else if (step) begin
			rem_q <= {rem_nx[COORD_BITS-1:0], 1'b0};
			quo_q <= quo;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dlr_datapath.sv =====
`default_nettype none
module dlr_datapath import dlr_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dlr_cmd_t                cmd,
	output dlr_status_t             status,
	input  logic [PORT_COORD_W-1:0] x_start,
	input  logic [PORT_COORD_W-1:0] y_start,
	input  logic [PORT_COORD_W-1:0] x_end,
	input  logic [PORT_COORD_W-1:0] y_end,
	output logic [PORT_COORD_W-1:0] pix_x,
	output logic [PORT_COORD_W-1:0] pix_y,
	output logic                    last,
	output logic                    stale
);

	localparam int ACC_W  = COORD_BITS + FRAC_BITS;
	localparam int INC_W  = FRAC_BITS + 2;
	localparam int STEP_W = COORD_BITS + 1;
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

	logic [COORD_BITS-1:0] xs, ys, xe, ye;
	logic signed [COORD_BITS:0] dx, dy, adx, ady;
	logic [COORD_BITS-1:0] ax, ay, steps;

	logic [ACC_W-1:0]      acc_x_q, acc_y_q;
	logic [INC_W-1:0]      inc_x_q, inc_y_q;
	logic [STEP_W-1:0]     steps_left_q;
	logic [COORD_BITS-1:0] end_x_q, end_y_q;
	logic                  line_active_q;
	logic                  neg_x_q, neg_y_q;
	logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
	logic                  last_q, stale_q;

	logic [FRAC_BITS:0] quo_x, quo_y;
	logic [INC_W-1:0]   qx_ext, qy_ext;
	logic [ACC_W-1:0]   sum_x, sum_y, rnd_x, rnd_y, held_x, held_y;
	logic [ACC_W-1:0]   end_acc_x, end_acc_y;
	logic [COORD_BITS-1:0] nx_pix_x, nx_pix_y;
	logic                  nx_last, nx_stale;

	assign xs = COORD_BITS'(x_start);
	assign ys = COORD_BITS'(y_start);
	assign xe = COORD_BITS'(x_end);
	assign ye = COORD_BITS'(y_end);

	assign dx  = $signed({1'b0, xe}) - $signed({1'b0, xs});
	assign dy  = $signed({1'b0, ye}) - $signed({1'b0, ys});
	assign adx = dx[COORD_BITS] ? -dx : dx;
	assign ady = dy[COORD_BITS] ? -dy : dy;
	assign ax  = adx[COORD_BITS-1:0];
	assign ay  = ady[COORD_BITS-1:0];
	assign steps = (ax > ay) ? ax : ay;

	assign status.zero_len    = steps == '0;
	assign status.line_active = line_active_q;
	assign status.last_step   = steps_left_q == STEP_W'(1);

	dlr_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk   (clk),
		.load  (cmd.start),
		.step  (cmd.div_step),
		.mag   (ax),
		.steps (steps),
		.quo   (quo_x)
	);

	dlr_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk   (clk),
		.load  (cmd.start),
		.step  (cmd.div_step),
		.mag   (ay),
		.steps (steps),
		.quo   (quo_y)
	);

	// sign applied after the divide: rounds toward zero
	assign qx_ext = {1'b0, quo_x};
	assign qy_ext = {1'b0, quo_y};

	assign sum_x  = acc_x_q + {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
	assign sum_y  = acc_y_q + {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
	assign rnd_x  = sum_x + HALF;
	assign rnd_y  = sum_y + HALF;
	assign held_x = acc_x_q + HALF;
	assign held_y = acc_y_q + HALF;

	assign end_acc_x = {end_x_q, {FRAC_BITS{1'b0}}};
	assign end_acc_y = {end_y_q, {FRAC_BITS{1'b0}}};

	always_comb begin
		nx_pix_x = held_x[ACC_W-1:FRAC_BITS];
		nx_pix_y = held_y[ACC_W-1:FRAC_BITS];
		nx_last  = 1'b0;
		nx_stale = 1'b0;
		if (cmd.start) begin
			nx_pix_x = xs;
			nx_pix_y = ys;
			nx_last  = status.zero_len;
		end else if (cmd.advance) begin
			if (status.last_step) begin
				nx_pix_x = end_x_q;
				nx_pix_y = end_y_q;
				nx_last  = 1'b1;
			end else begin
				nx_pix_x = rnd_x[ACC_W-1:FRAC_BITS];
				nx_pix_y = rnd_y[ACC_W-1:FRAC_BITS];
			end
		end else begin
			nx_stale = cmd.stale;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q       <= '0;
			acc_y_q       <= '0;
			line_active_q <= 1'b0;
		end else if (cmd.start) begin
			acc_x_q       <= {xs, {FRAC_BITS{1'b0}}};
			acc_y_q       <= {ys, {FRAC_BITS{1'b0}}};
			line_active_q <= !status.zero_len;
		end else if (cmd.advance) begin
			if (status.last_step) begin
				acc_x_q       <= end_acc_x;
				acc_y_q       <= end_acc_y;
				line_active_q <= 1'b0;
			end else begin
				acc_x_q <= sum_x;
				acc_y_q <= sum_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			end_x_q      <= xe;
			end_y_q      <= ye;
			neg_x_q      <= dx[COORD_BITS];
			neg_y_q      <= dy[COORD_BITS];
			steps_left_q <= {1'b0, steps};
		end else if (cmd.advance) begin
			steps_left_q <= steps_left_q - STEP_W'(1);
		end
		if (cmd.div_last) begin
			inc_x_q <= neg_x_q ? -qx_ext : qx_ext;
			inc_y_q <= neg_y_q ? -qy_ext : qy_ext;
		end
		if (cmd.load_out) begin
			pix_x_q <= nx_pix_x;
			pix_y_q <= nx_pix_y;
			last_q  <= nx_last;
			stale_q <= nx_stale;
		end
	end

	assign pix_x = PORT_COORD_W'(pix_x_q);
	assign pix_y = PORT_COORD_W'(pix_y_q);
	assign last  = last_q;
	assign stale = stale_q;

endmodule
`default_nettype wire

// ===== rtl/dlr_controller.sv =====
`default_nettype none
module dlr_controller import dlr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_type,
	output logic        req_ready,
	output logic        pix_valid,
	input  logic        pix_ready,
	input  dlr_status_t status,
	output dlr_cmd_t    cmd
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_DIVIDE = 2'b10
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             pix_valid_q;
	logic             accept;

	assign req_ready = (state_q == ST_IDLE) && (!pix_valid_q || pix_ready);
	assign accept    = req_valid && req_ready;
	assign pix_valid = pix_valid_q;

	always_comb begin
		cmd.load_out = accept;
		cmd.start    = accept && (req_type == REQ_START);
		cmd.advance  = accept && (req_type == REQ_ADVANCE) && status.line_active;
		cmd.stale    = accept && (req_type == REQ_ADVANCE) && !status.line_active;
		cmd.div_step = state_q == ST_DIVIDE;
		cmd.div_last = cmd.div_step && (cnt_q == CNT_W'(FRAC_BITS));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start && !status.zero_len)
					state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (cmd.div_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIVIDE)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
			if (accept)
				pix_valid_q <= 1'b1;
			else if (pix_ready)
				pix_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dda_line_rasterizer.sv =====
// DDA line rasteriser.
// req: one word per request. req_type start loads both endpoints and yields
//   the first endpoint; req_type advance yields the next pixel of the line.
// pix: one word per request: pixel column and row, last on the end point,
//   stale when an advance came with no line in progress (the held pixel
//   is repeated).
// Result: registered; it sits in the output register in the cycle after the
//   request word is taken.
// Throughput: advances and zero-length starts, one word a cycle unless pix.ready stalls
//   the output. A start of a line with length runs both per-axis restoring dividers,
//   one quotient bit a cycle, with req.ready low; the first pixel is already on pix
//   meanwhile.
// Reset: asynchronous, empties the output register, clears the accumulators
//   (the held pixel is 0,0) and ends any line.
// Stall: a pending result is held while pix.ready is low; a new request is
//   taken in the cycle pix.ready frees the output register, unless a divide runs.
`include "dda_line_rasterizer_macros.svh"
`default_nettype none
module dda_line_rasterizer import dlr_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	dlr_req_if.sink   req,
	dlr_pix_if.source pix
);

	dlr_cmd_t    cmd;
	dlr_status_t status;

	dlr_controller #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dlr_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.x_start (req.x_start),
		.y_start (req.y_start),
		.x_end   (req.x_end),
		.y_end   (req.y_end),
		.pix_x   (pix.pix_x),
		.pix_y   (pix.pix_y),
		.last    (pix.last),
		.stale   (pix.stale)
	);

	`DLR_ASSERT(a_no_req_in_divide, cmd.div_step |-> !req.ready, "request taken mid-divide")
	`DLR_ASSERT_NEXT(a_word_to_output, req.valid && req.ready, pix.valid, "result word lost")
	`DLR_ASSERT(a_last_not_stale, pix.valid |-> !(pix.last && pix.stale), "last and stale both set")
	`DLR_ASSERT_NEXT(a_start_divides, cmd.start && !status.zero_len, cmd.div_step,
		"divider not started")

endmodule
`default_nettype wire

// ===== verif/tb_dda_line_rasterizer.sv =====
`default_nettype none
module tb_dda_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	import dlr_pkg::*;

	localparam int CW           = PORT_COORD_W;
	localparam int FW           = 16;
	localparam int CLK_PERIOD   = 20;
	localparam int TOTAL_WORDS  = 1200;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AFTER   = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CW-1:0] C_MAX = '1;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          last;
		logic          stale;
	} pixel_word_t;

	class pixel_scoreboard;
		logic [CW+FW-1:0]   acc_x, acc_y;
		logic signed [FW+1:0] inc_x, inc_y;
		logic [CW:0]        steps_left;
		logic [CW-1:0]      end_x, end_y;
		bit                 line_active;
		pixel_word_t        expected_q[$];
		int unsigned        mismatches;

		function new();
			acc_x       = '0;
			acc_y       = '0;
			inc_x       = '0;
			inc_y       = '0;
			steps_left  = '0;
			end_x       = '0;
			end_y       = '0;
			line_active = 1'b0;
			mismatches  = 0;
		endfunction

		function logic [CW-1:0] round_half_up(logic [CW+FW-1:0] acc);
			logic [CW+FW:0] sum;
			sum = {1'b0, acc} + ((CW+FW+1)'(1) << (FW-1));
			return sum[FW +: CW];
		endfunction

		// magnitude divided, sign applied after: rounds toward zero
		function logic signed [FW+1:0] axis_increment(int delta, int steps);
			int mag;
			int q;
			mag = (delta < 0) ? -delta : delta;
			q   = (mag << FW) / steps;
			return (FW+2)'((delta < 0) ? -q : q);
		endfunction

		function void note_word(logic rt, logic [CW-1:0] xs, logic [CW-1:0] ys,
				logic [CW-1:0] xe, logic [CW-1:0] ye);
			pixel_word_t w;
			int dx, dy, ax, ay, steps;
			w = '0;
			if (rt == REQ_START) begin
				dx    = int'(xe) - int'(xs);
				dy    = int'(ye) - int'(ys);
				ax    = (dx < 0) ? -dx : dx;
				ay    = (dy < 0) ? -dy : dy;
				steps = (ax > ay) ? ax : ay;
				acc_x = {xs, {FW{1'b0}}};
				acc_y = {ys, {FW{1'b0}}};
				end_x = xe;
				end_y = ye;
				if (steps == 0) begin
					inc_x       = '0;
					inc_y       = '0;
					steps_left  = '0;
					line_active = 1'b0;
					w.last      = 1'b1;
				end else begin
					inc_x       = axis_increment(dx, steps);
					inc_y       = axis_increment(dy, steps);
					steps_left  = (CW+1)'(steps);
					line_active = 1'b1;
				end
			end else if (line_active) begin
				acc_x      = acc_x + (CW+FW)'(inc_x);
				acc_y      = acc_y + (CW+FW)'(inc_y);
				steps_left = steps_left - 1'b1;
				if (steps_left == '0) begin
					acc_x       = {end_x, {FW{1'b0}}};
					acc_y       = {end_y, {FW{1'b0}}};
					line_active = 1'b0;
					w.last      = 1'b1;
				end
			end else begin
				w.stale = 1'b1;
			end
			w.x = round_half_up(acc_x);
			w.y = round_half_up(acc_y);
			expected_q.push_back(w);
		endfunction

		function void check_word(logic [CW-1:0] x, logic [CW-1:0] y, logic last,
				logic stale);
			pixel_word_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected pixel word x=%0d y=%0d last=%0b stale=%0b",
						$realtime, x, y, last, stale);
				return;
			end
			want = expected_q.pop_front();
			if (x !== want.x || y !== want.y || last !== want.last || stale !== want.stale) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: pixel mismatch: expected x=%0d y=%0d last=%0b stale=%0b,",
						" got x=%0d y=%0d last=%0b stale=%0b"},
						$realtime, want.x, want.y, want.last, want.stale, x, y, last, stale);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dlr_req_if req_bus ();
	dlr_pix_if pix_bus ();

	dda_line_rasterizer #(
		.COORD_BITS(CW),
		.FRAC_BITS (FW)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus.sink),
		.pix   (pix_bus.source)
	);

	pixel_scoreboard sb;
	int words_sent  = 0;
	int burst_left  = 0;
	int pixels_seen = 0;
	int idle_cycles = 0;

	always #(CLK_PERIOD/2) clk = ~clk;

	function automatic int line_steps(logic [CW-1:0] xs, logic [CW-1:0] ys,
			logic [CW-1:0] xe, logic [CW-1:0] ye);
		int ax, ay;
		ax = int'(xe) - int'(xs);
		ay = int'(ye) - int'(ys);
		if (ax < 0) ax = -ax;
		if (ay < 0) ay = -ay;
		return (ax > ay) ? ax : ay;
	endfunction

	function automatic logic [CW-1:0] clamp_coord(int v);
		if (v < 0) return '0;
		if (v > int'(C_MAX)) return C_MAX;
		return CW'(v);
	endfunction

	task automatic send_word(logic rt, logic [CW-1:0] xs, logic [CW-1:0] ys,
			logic [CW-1:0] xe, logic [CW-1:0] ye);
		int gap;
		if (burst_left == 0) begin
			req_bus.valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		req_bus.valid    <= 1'b1;
		req_bus.req_type <= rt;
		req_bus.x_start  <= xs;
		req_bus.y_start  <= ys;
		req_bus.x_end    <= xe;
		req_bus.y_end    <= ye;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		words_sent++;
	endtask

	// endpoint fields carry noise on advances
	task automatic advance_words(int n);
		repeat (n) send_word(REQ_ADVANCE, CW'($urandom), CW'($urandom), CW'($urandom),
			CW'($urandom));
	endtask

	task automatic run_line(logic [CW-1:0] xs, logic [CW-1:0] ys, logic [CW-1:0] xe,
			logic [CW-1:0] ye, int n);
		send_word(REQ_START, xs, ys, xe, ye);
		advance_words(n);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				sb.note_word(req_bus.req_type, req_bus.x_start, req_bus.y_start,
					req_bus.x_end, req_bus.y_end);
			if (pix_bus.valid && pix_bus.ready) begin
				sb.check_word(pix_bus.pix_x, pix_bus.pix_y, pix_bus.last, pix_bus.stale);
				pixels_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_dda_line_rasterizer: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int seg;
		int k;
		bit held_off;
		rx_mode_t mode;
		pix_bus.ready <= 1'b0;
		held_off = 1'b0;
		seg      = 0;
		k        = 2;
		mode     = RX_ALWAYS;
		forever begin
			@(posedge clk);
			if (!held_off && pixels_seen >= HOLD_AFTER) begin
				// long hold-off so the block backs up onto its input
				held_off = 1'b1;
				pix_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (seg == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				seg  = $urandom_range(20, 200);
				k    = $urandom_range(2, 6);
			end
			seg--;
			case (mode)
				RX_ALWAYS: pix_bus.ready <= 1'b1;
				RX_RANDOM: pix_bus.ready <= ($urandom_range(0, 99) < 60);
				default:   pix_bus.ready <= ((seg % k) != 0);
			endcase
		end
	end

	initial begin
		int r, dx, dy, steps, n, target;
		logic [CW-1:0] xs, ys, xe, ye;
		sb = new();
		arst_n           <= 1'b0;
		req_bus.valid    <= 1'b0;
		req_bus.req_type <= REQ_START;
		req_bus.x_start  <= '0;
		req_bus.y_start  <= '0;
		req_bus.x_end    <= '0;
		req_bus.y_end    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance straight after reset: stale at 0,0
		advance_words(1);
		run_line('0, '0, '0, '0, 0);
		run_line(C_MAX, C_MAX, C_MAX, C_MAX, 1);
		// lines left running, so the next start restarts a line still in progress
		run_line('0, '0, C_MAX, C_MAX, 3);
		run_line(C_MAX, '0, '0, C_MAX, 2);
		run_line(CW'(3), CW'(9), CW'(5), CW'(2), 8);
		run_line(C_MAX, C_MAX, CW'(1021), C_MAX, 3);

		// full-length line run to its end point
		run_line('0, C_MAX, C_MAX, '0, line_steps('0, C_MAX, C_MAX, '0));

		target = TOTAL_WORDS;
		while (words_sent < target) begin
			r  = $urandom_range(0, 99);
			xs = CW'($urandom);
			ys = CW'($urandom);
			if (r < 70) begin
				dx    = int'($urandom_range(0, 48)) - 24;
				dy    = int'($urandom_range(0, 48)) - 24;
				xe    = clamp_coord(int'(xs) + dx);
				ye    = clamp_coord(int'(ys) + dy);
				steps = line_steps(xs, ys, xe, ye);
				n     = steps;
				if (steps > 0 && $urandom_range(0, 6) == 0)
					n = $urandom_range(0, steps - 1);
				else if ($urandom_range(0, 4) == 0)
					n = steps + $urandom_range(1, 3);
				run_line(xs, ys, xe, ye, n);
			end else if (r < 80) begin
				xe    = CW'($urandom);
				ye    = CW'($urandom);
				steps = line_steps(xs, ys, xe, ye);
				n     = (steps <= 40) ? steps + $urandom_range(0, 2) : $urandom_range(0, 30);
				run_line(xs, ys, xe, ye, n);
			end else if (r < 90) begin
				run_line(xs, ys, xs, ys, $urandom_range(0, 2));
			end else begin
				advance_words($urandom_range(1, 4));
			end
		end

		req_bus.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("tb_dda_line_rasterizer: PASS");
		end else begin
			$display("tb_dda_line_rasterizer: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== dda_line_rasterizer.f =====
+incdir+rtl
rtl/dlr_pkg.sv
rtl/dlr_if.sv
rtl/dlr_divider.sv
rtl/dlr_datapath.sv
rtl/dlr_controller.sv
rtl/dda_line_rasterizer.sv
verif/tb_dda_line_rasterizer.sv
